FILE: design/assert_macros.svh
// assertion macros for the checker file of the go-to-goal block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define GTG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtg check failed");

// next-cycle implication, also checked during reset
`define GTG_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gtg check failed");

`endif

FILE: design/gtg_pkg.sv
// types, constants and helper functions of the go-to-goal velocity block
// no dependencies
package gtg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 16;

   localparam int CIN_W    = 36;   // cordic operand width
   localparam int PRE_W    = 37;   // after the quarter-turn pre-rotation
   localparam int CW       = 45;   // cordic datapath width
   localparam int ANG_W    = 32;   // angle, Q8.24
   localparam int NORM_BIT = 40;   // normalized magnitude msb
   localparam int SH_W     = 6;

   localparam int CORDIC_LAT = 3 + CORDIC_STEPS;
   localparam int SQRT_LAT   = 1 + SQRT_STEPS;
   localparam int ANG_PAD    = (SQRT_LAT > CORDIC_LAT) ? SQRT_LAT - CORDIC_LAT : 0;
   localparam int DIST_PAD   = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT - SQRT_LAT : 0;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DIST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_HEAD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRES = 3'd4;

   localparam logic [15:0] GAIN_RESET = 16'd2048;
   localparam logic [30:0] THRES_RESET = 31'd6554;

   localparam logic signed [ANG_W-1:0] HALF_PI = 32'sd26353589;
   localparam logic signed [ANG_W-1:0] ATAN_TABLE [11] = '{
      32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331, 32'sd1047214,
      32'sd524117, 32'sd262123, 32'sd131069, 32'sd65536, 32'sd32768, 32'sd16384
   };

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
      logic               goal_reached;
   } rsp_type;

   // front end to the cordic and root pipelines
   typedef struct packed {
      logic signed [CIN_W-1:0] yaw_y;
      logic signed [CIN_W-1:0] yaw_x;
      logic signed [CIN_W-1:0] dy;
      logic signed [CIN_W-1:0] dx;
      logic [29:0]             dx2;
      logic [29:0]             dy2;
      logic                    near;
   } front_type;

   typedef struct packed {
      logic [15:0] root;
      logic        near;
   } dist_type;

   function automatic logic signed [ANG_W-1:0] atan_step(input int i);
      if (i < 11)
         return ATAN_TABLE[4'(i)];
      else if (i <= 24)
         return ANG_W'(1) << (24 - i);
      else
         return '0;
   endfunction

   function automatic logic [SH_W-1:0] msb_pos(input logic [PRE_W-1:0] v);
      logic [SH_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < PRE_W; i++) begin
         if (v[i])
            pos = SH_W'(i);
      end
      return pos;
   endfunction

endpackage

FILE: design/gtg_front.sv
// front end: goal offsets, quaternion products, yaw operands and squared offsets
// depends on gtg_pkg
module gtg_front import gtg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_type            in_data,
   input  logic signed [31:0] goal_x,
   input  logic signed [31:0] goal_y,
   output logic               out_valid,
   output front_type          out_data
);

   logic               v1_ff;
   logic signed [32:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xz_ff, wy_ff, wz_ff, xy_ff;
   logic signed [31:0] xx_in, yy_in, zz_in, ww_in, xz_in, wy_in, wz_in, xy_in;

   logic               v2_ff;
   front_type          f_ff, f_in;
   logic signed [33:0] n_sum, s_val, yy_zz;
   logic signed [34:0] s_abs;
   logic signed [15:0] dx16, dy16;
   logic signed [31:0] dx2_full, dy2_full;

   // stage 1
   always_comb begin
      dx_in = 33'(goal_x) - 33'(in_data.pos_x);
      dy_in = 33'(goal_y) - 33'(in_data.pos_y);
      xx_in = in_data.quat_x * in_data.quat_x;
      yy_in = in_data.quat_y * in_data.quat_y;
      zz_in = in_data.quat_z * in_data.quat_z;
      ww_in = in_data.quat_w * in_data.quat_w;
      xz_in = in_data.quat_x * in_data.quat_z;
      wy_in = in_data.quat_w * in_data.quat_y;
      wz_in = in_data.quat_w * in_data.quat_z;
      xy_in = in_data.quat_x * in_data.quat_y;
   end

   // stage 2
   always_comb begin
      n_sum = 34'(xx_ff) + 34'(yy_ff) + 34'(zz_ff) + 34'(ww_ff);
      s_val = (34'(xz_ff) - 34'(wy_ff)) <<< 1;
      s_abs = (s_val < 0) ? -35'(s_val) : 35'(s_val);
      yy_zz = (34'(yy_ff) + 34'(zz_ff)) <<< 1;
      dx16  = dx_ff[15:0];
      dy16  = dy_ff[15:0];
      dx2_full = dx16 * dx16;
      dy2_full = dy16 * dy16;

      f_in.dx   = CIN_W'(dx_ff);
      f_in.dy   = CIN_W'(dy_ff);
      f_in.dx2  = dx2_full[29:0];
      f_in.dy2  = dy2_full[29:0];
      f_in.near = (dx_ff >= -33'sd32767) && (dx_ff <= 33'sd32767) &&
                  (dy_ff >= -33'sd32767) && (dy_ff <= 33'sd32767);
      // gimbal lock: a zero vector makes the yaw zero
      if (s_abs >= 35'(n_sum)) begin
         f_in.yaw_y = '0;
         f_in.yaw_x = '0;
      end else begin
         f_in.yaw_y = CIN_W'((34'(wz_ff) + 34'(xy_ff)) <<< 1);
         f_in.yaw_x = CIN_W'(35'(n_sum) - 35'(yy_zz));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      zz_ff <= zz_in;
      ww_ff <= ww_in;
      xz_ff <= xz_in;
      wy_ff <= wy_in;
      wz_ff <= wz_in;
      xy_ff <= xy_in;
      f_ff  <= f_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = f_ff;

endmodule

FILE: design/gtg_cordic.sv
// pipelined vectoring cordic: atan2(y, x) in Q8.24, one rotation per stage
// depends on gtg_pkg
module gtg_cordic import gtg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [CIN_W-1:0] in_y,
   input  logic signed [CIN_W-1:0] in_x,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_angle
);

   logic                    va_ff, za_ff, za_in;
   logic signed [PRE_W-1:0] xa_ff, ya_ff, xa_in, ya_in;
   logic signed [ANG_W-1:0] anga_ff, anga_in;

   logic                    vb_ff, zb_ff;
   logic signed [PRE_W-1:0] xb_ff, yb_ff, yb_abs;
   logic signed [ANG_W-1:0] angb_ff;
   logic [SH_W-1:0]         shb_ff, shb_in;

   logic                    v_ff [CORDIC_STEPS+1];
   logic                    z_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    y_ff [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] ang_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    x_in [CORDIC_STEPS];
   logic signed [CW-1:0]    y_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0] ang_in [CORDIC_STEPS];

   // quarter-turn pre-rotation into the right half plane
   always_comb begin
      za_in   = (in_x == '0) && (in_y == '0);
      xa_in   = PRE_W'(in_x);
      ya_in   = PRE_W'(in_y);
      anga_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            xa_in   = PRE_W'(in_y);
            ya_in   = -PRE_W'(in_x);
            anga_in = HALF_PI;
         end else begin
            xa_in   = -PRE_W'(in_y);
            ya_in   = PRE_W'(in_x);
            anga_in = -HALF_PI;
         end
      end
   end

   // scale so the larger magnitude lands at bit NORM_BIT
   always_comb begin
      yb_abs = (ya_ff < 0) ? -ya_ff : ya_ff;
      shb_in = SH_W'(NORM_BIT) - msb_pos(xa_ff | yb_abs);
   end

   always_comb begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (y_ff[k] >= 0) begin
            x_in[k]   = x_ff[k] + (y_ff[k] >>> k);
            y_in[k]   = y_ff[k] - (x_ff[k] >>> k);
            ang_in[k] = ang_ff[k] + atan_step(k);
         end else begin
            x_in[k]   = x_ff[k] - (y_ff[k] >>> k);
            y_in[k]   = y_ff[k] + (x_ff[k] >>> k);
            ang_in[k] = ang_ff[k] - atan_step(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int k = 0; k <= CORDIC_STEPS; k++)
            v_ff[k] <= 1'b0;
      end else begin
         va_ff   <= in_valid;
         vb_ff   <= va_ff;
         v_ff[0] <= vb_ff;
         for (int k = 0; k < CORDIC_STEPS; k++)
            v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      xa_ff   <= xa_in;
      ya_ff   <= ya_in;
      anga_ff <= anga_in;
      za_ff   <= za_in;
      xb_ff   <= xa_ff;
      yb_ff   <= ya_ff;
      angb_ff <= anga_ff;
      zb_ff   <= za_ff;
      shb_ff  <= shb_in;
      x_ff[0]   <= CW'(xb_ff) <<< shb_ff;
      y_ff[0]   <= CW'(yb_ff) <<< shb_ff;
      ang_ff[0] <= angb_ff;
      z_ff[0]   <= zb_ff;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         x_ff[k+1]   <= x_in[k];
         y_ff[k+1]   <= y_in[k];
         ang_ff[k+1] <= ang_in[k];
         z_ff[k+1]   <= z_ff[k];
      end
   end

   assign out_valid = v_ff[CORDIC_STEPS];
   assign out_angle = z_ff[CORDIC_STEPS] ? '0 : ang_ff[CORDIC_STEPS];

endmodule

FILE: design/gtg_isqrt.sv
// pipelined integer square root of dx^2 + dy^2, one result bit per stage
// depends on gtg_pkg
module gtg_isqrt import gtg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [29:0] in_dx2,
   input  logic [29:0] in_dy2,
   input  logic        in_near,
   output logic        out_valid,
   output dist_type    out_data
);

   logic        v_ff [SQRT_STEPS+1];
   logic        n_ff [SQRT_STEPS+1];
   logic [31:0] rem_ff [SQRT_STEPS+1];
   logic [31:0] r_ff [SQRT_STEPS+1];
   logic [31:0] rem_in [SQRT_STEPS];
   logic [31:0] r_in [SQRT_STEPS];

   always_comb begin
      logic [31:0] bit_val;
      logic [31:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         bit_val = 32'(1) << (2 * (SQRT_STEPS - 1 - k));
         trial   = r_ff[k] + bit_val;
         if (rem_ff[k] >= trial) begin
            rem_in[k] = rem_ff[k] - trial;
            r_in[k]   = (r_ff[k] >> 1) + bit_val;
         end else begin
            rem_in[k] = rem_ff[k];
            r_in[k]   = r_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQRT_STEPS; k++)
            v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < SQRT_STEPS; k++)
            v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= 32'(in_dx2) + 32'(in_dy2);
      r_ff[0]   <= '0;
      n_ff[0]   <= in_near;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         rem_ff[k+1] <= rem_in[k];
         r_ff[k+1]   <= r_in[k];
         n_ff[k+1]   <= n_ff[k];
      end
   end

   assign out_valid     = v_ff[SQRT_STEPS];
   assign out_data.root = r_ff[SQRT_STEPS][15:0];
   assign out_data.near = n_ff[SQRT_STEPS];

endmodule

FILE: design/go_to_goal_velocity_command.sv
// go-to-goal proportional velocity controller, top level
// depends on gtg_pkg, gtg_front, gtg_cordic, gtg_isqrt
//
// One odometry sample (position Q16.16, quaternion Q1.14) enters on req_data
// at a clock edge with start high and busy low; busy stays low, so a sample
// can enter every cycle. Each sample gives one command on rsp_data, shown for
// exactly one cycle with rsp_valid high, in order. The command passes through
// two front-end stages, two parallel cordic pipelines (three set-up stages plus
// one per rotation) beside a square root pipeline, then three output stages.
// The receiver cannot stall, so nothing is ever held back.
// Goal, gains and stop threshold go in on the csr_ channel (always ready); the
// user must write them only while no sample is in flight, which the block
// does not enforce. Reset, synchronous and active high, drops every sample in
// flight and loads goal 0, gains 0.5 and threshold 0.1.
module go_to_goal_velocity_command import gtg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic [15:0]        gain_d_ff, gain_h_ff;
   logic [30:0]        thres_ff;

   logic               f_valid;
   front_type          f_data;
   logic               yaw_valid, brg_valid, sq_valid;
   logic signed [ANG_W-1:0] yaw_ang, brg_ang;
   dist_type           sq_data;

   logic               a_valid;
   logic signed [ANG_W-1:0] a_yaw, a_brg;
   dist_type           d_data;

   logic               t1_v_ff, t2_v_ff, out_v_ff;
   logic signed [32:0] ea;
   logic signed [25:0] ea_clamp;
   logic signed [17:0] q16_ff, q16_in;
   logic [15:0]        ed_ff, ed_in;
   logic [31:0]        pd;
   logic signed [34:0] pa;
   logic [19:0]        err_d_ff;
   logic signed [22:0] err_a_ff;
   rsp_type            rsp_ff, rsp_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         gain_d_ff <= GAIN_RESET;
         gain_h_ff <= GAIN_RESET;
         thres_ff  <= THRES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GOAL_X:     goal_x_ff <= csr_wdata;
            CSR_GOAL_Y:     goal_y_ff <= csr_wdata;
            CSR_GAIN_DIST:  gain_d_ff <= csr_wdata[15:0];
            CSR_GAIN_HEAD:  gain_h_ff <= csr_wdata[15:0];
            CSR_STOP_THRES: thres_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   gtg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .goal_x    (goal_x_ff),
      .goal_y    (goal_y_ff),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   gtg_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_y      (f_data.yaw_y),
      .in_x      (f_data.yaw_x),
      .out_valid (yaw_valid),
      .out_angle (yaw_ang)
   );

   gtg_cordic u_bearing (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_y      (f_data.dy),
      .in_x      (f_data.dx),
      .out_valid (brg_valid),
      .out_angle (brg_ang)
   );

   gtg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_dx2    (f_data.dx2),
      .in_dy2    (f_data.dy2),
      .in_near   (f_data.near),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   // line up the angle and distance paths
   generate
      if (ANG_PAD > 0) begin : g_ang_pad
         logic                    pv_ff [ANG_PAD];
         logic signed [ANG_W-1:0] py_ff [ANG_PAD];
         logic signed [ANG_W-1:0] pb_ff [ANG_PAD];
         always_ff @(posedge clock) begin
            if (reset) begin
               for (int j = 0; j < ANG_PAD; j++)
                  pv_ff[j] <= 1'b0;
            end else begin
               pv_ff[0] <= brg_valid && yaw_valid;
               for (int j = 1; j < ANG_PAD; j++)
                  pv_ff[j] <= pv_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            py_ff[0] <= yaw_ang;
            pb_ff[0] <= brg_ang;
            for (int j = 1; j < ANG_PAD; j++) begin
               py_ff[j] <= py_ff[j-1];
               pb_ff[j] <= pb_ff[j-1];
            end
         end
         assign a_valid = pv_ff[ANG_PAD-1];
         assign a_yaw   = py_ff[ANG_PAD-1];
         assign a_brg   = pb_ff[ANG_PAD-1];
      end else begin : g_ang_direct
         assign a_valid = brg_valid && yaw_valid;
         assign a_yaw   = yaw_ang;
         assign a_brg   = brg_ang;
      end

      if (DIST_PAD > 0) begin : g_dist_pad
         dist_type pd_ff [DIST_PAD];
         always_ff @(posedge clock) begin
            pd_ff[0] <= sq_data;
            for (int j = 1; j < DIST_PAD; j++)
               pd_ff[j] <= pd_ff[j-1];
         end
         assign d_data = pd_ff[DIST_PAD-1];
      end else begin : g_dist_direct
         assign d_data = sq_data;
      end
   endgenerate

   // the root path's valid runs alongside and carries no extra information
   logic sq_unused;
   assign sq_unused = sq_valid;

   // heading error clamp and Q8.24 to Q16.16, distance clamp
   always_comb begin
      ea = 33'(a_brg) - 33'(a_yaw);
      if (ea > 33'sd16777216)
         ea_clamp = 26'sd16777216;
      else if (ea < -33'sd16777216)
         ea_clamp = -26'sd16777216;
      else
         ea_clamp = ea[25:0];
      q16_in = 18'((ea_clamp + 26'sd128) >>> 8);
      if (!d_data.near || d_data.root > 16'd32768)
         ed_in = 16'd32768;
      else
         ed_in = d_data.root;
   end

   always_comb begin
      pd = 32'(gain_d_ff) * 32'(ed_ff);
      pa = $signed({19'b0, gain_h_ff}) * 35'(q16_ff);
   end

   always_comb begin
      rsp_in.goal_reached = !({11'b0, err_d_ff} > thres_ff);
      if (rsp_in.goal_reached) begin
         rsp_in.linear_velocity  = '0;
         rsp_in.angular_velocity = '0;
      end else begin
         rsp_in.linear_velocity  = $signed({12'b0, err_d_ff});
         rsp_in.angular_velocity = 32'(err_a_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff  <= 1'b0;
         t2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         t1_v_ff  <= a_valid;
         t2_v_ff  <= t1_v_ff;
         out_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      q16_ff   <= q16_in;
      ed_ff    <= ed_in;
      err_d_ff <= pd[31:12];
      err_a_ff <= pa[34:12];
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/gtg_checker.sv
// port-level checks on the go-to-goal velocity block, bound to the top level
// depends on gtg_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtg_checker import gtg_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // reached goal means a zero command
   `GTG_ASSERT_IMP(a_reached_zero, clock, reset, rsp_valid && rsp_data.goal_reached, rsp_data.linear_velocity == 32'sd0 && rsp_data.angular_velocity == 32'sd0)

   // linear speed is a clamped distance times a Q4.12 gain: below 2^19
   `GTG_ASSERT_IMP(a_linear_range, clock, reset, rsp_valid, rsp_data.linear_velocity[31:19] == 13'd0)

   // turn rate stays within a clamped angle times the largest gain
   `GTG_ASSERT_IMP(a_angular_range, clock, reset, rsp_valid, rsp_data.angular_velocity[31:20] == 12'h000 || rsp_data.angular_velocity[31:20] == 12'hfff)

   // reset flushes every beat in flight
   `GTG_ASSERT_NXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind go_to_goal_velocity_command gtg_checker u_gtg_checker (.*);
